// ===== rtl/ra_decl_position_jacobian_top_defines.svh =====
// Assertion macros for the RA/declination Jacobian block.
// Used by modules that have clk and arst_n in scope.
`ifndef RA_DECL_POSITION_JACOBIAN_TOP_DEFINES_SVH
`define RA_DECL_POSITION_JACOBIAN_TOP_DEFINES_SVH

// same-cycle implication
`define RDJ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rdj assertion failed");

// next-cycle implication
`define RDJ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rdj assertion failed");

`endif

// ===== rtl/rdj_pkg.sv =====
// Package for the RA/declination Jacobian block.
// Transaction types, pipeline constants and the front-end result type.
package rdj_pkg;

	localparam int unsigned SQ_STEPS = 64;
	localparam int unsigned QUO_BITS = 48;
	localparam int unsigned FRONT_LAT = 3;
	localparam int unsigned MUL_LAT = 3;
	localparam int unsigned DIV_LAT = QUO_BITS + 2;
	localparam int unsigned PIPE_LAT = FRONT_LAT + SQ_STEPS + MUL_LAT + DIV_LAT;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} pos_t;

	typedef struct packed {
		logic signed [47:0] dra_dx;
		logic signed [47:0] dra_dy;
		logic signed [47:0] ddecl_dx;
		logic signed [47:0] ddecl_dy;
		logic signed [47:0] ddecl_dz;
		logic on_axis;
	} jac_t;

	typedef struct packed {
		logic [31:0] mx;
		logic [31:0] my;
		logic [63:0] mxz;
		logic [63:0] myz;
		logic [63:0] s;
		logic [63:0] r2;
		logic nx;
		logic ny;
		logic nz;
		logic axis;
	} front_t;

endpackage

// ===== rtl/ra_decl_position_jacobian_top.sv =====
// Top level of the RA/declination Jacobian: front end, square root, divisor
// product, five dividers and the output register. Depends on rdj_pkg, the defines header and the rdj_* modules.
//
//   channel | valid     | ready     | payload            | direction
//   --------+-----------+-----------+--------------------+----------
//   input   | pos_valid | pos_ready | pos (pos_t)        | in
//   result  | jac_valid | jac_ready | jac (jac_t)        | out
//
// One transaction enters per cycle while the result side does not stall; the pipeline
// has 3 front, 64 root, 3 product and 50 divider stages and an output register.
// The 64-step square root and the 48-bit divider chains set the depth.
// A stall at the result side freezes the whole pipeline; the first stage
// still takes a transaction while it is empty.
// Reset clears the valid bits only.
`include "ra_decl_position_jacobian_top_defines.svh"

module ra_decl_position_jacobian_top (
	input logic clk,
	input logic arst_n,
	input logic pos_valid,
	output logic pos_ready,
	input rdj_pkg::pos_t pos,
	output logic jac_valid,
	input logic jac_ready,
	output rdj_pkg::jac_t jac
);

	localparam int unsigned LAT = rdj_pkg::PIPE_LAT;
	localparam int unsigned DL = rdj_pkg::DIV_LAT;
	localparam int unsigned QB = rdj_pkg::QUO_BITS;

	typedef struct packed {
		logic neg_rx;
		logic neg_ry;
		logic neg_dx;
		logic neg_dy;
		logic axis;
	} side_t;

	logic en;
	logic [LAT-1:0] vld_s;
	logic jac_valid_q;
	rdj_pkg::jac_t jac_q;
	logic derivs_zero;

	rdj_pkg::front_t fr_f, fr_r, fr_m;
	logic [63:0] rho_r, rho_m;
	logic [127:0] dvsr_m;
	side_t side_s [DL];
	logic [QB:0] mag_rx, mag_ry, mag_dx, mag_dy, mag_dz;

	function automatic logic signed [47:0] pack48(input logic [QB:0] m, input logic neg);
		logic [QB:0] lim;
		begin
			lim = {2'b01, {(QB-1){1'b0}}};
			if (m == '0) begin
				pack48 = '0;
			end else if (neg) begin
				pack48 = (m > lim) ? {1'b1, 47'd0} : 48'(~m + 1'b1);
			end else begin
				pack48 = (m >= lim) ? {1'b0, {47{1'b1}}} : m[47:0];
			end
		end
	endfunction

	assign en = !jac_valid_q || jac_ready;
	assign pos_ready = en || !vld_s[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			jac_valid_q <= 1'b0;
		end else begin
			if (pos_ready) begin
				vld_s[0] <= pos_valid;
			end
			if (en) begin
				vld_s[LAT-1:1] <= vld_s[LAT-2:0];
				jac_valid_q <= vld_s[LAT-1];
			end
		end
	end

	rdj_front u_front (
		.clk(clk), .ld(pos_ready), .en(en), .pos(pos), .fr(fr_f)
	);

	rdj_sqrt u_sqrt (
		.clk(clk), .en(en), .fr_in(fr_f), .fr_out(fr_r), .rho(rho_r)
	);

	rdj_dmul u_dmul (
		.clk(clk), .en(en), .fr_in(fr_r), .rho_in(rho_r),
		.fr_out(fr_m), .rho_out(rho_m), .dvsr(dvsr_m)
	);

	rdj_div #(.DW(64)) u_div_rx (
		.clk(clk), .en(en), .rem0({32'd0, fr_m.my}), .low('0),
		.dvsr(fr_m.s), .mag(mag_rx)
	);

	rdj_div #(.DW(64)) u_div_ry (
		.clk(clk), .en(en), .rem0({32'd0, fr_m.mx}), .low('0),
		.dvsr(fr_m.s), .mag(mag_ry)
	);

	rdj_div #(.DW(128)) u_div_dx (
		.clk(clk), .en(en), .rem0({32'd0, fr_m.mxz, 32'd0}), .low('0),
		.dvsr(dvsr_m), .mag(mag_dx)
	);

	rdj_div #(.DW(128)) u_div_dy (
		.clk(clk), .en(en), .rem0({32'd0, fr_m.myz, 32'd0}), .low('0),
		.dvsr(dvsr_m), .mag(mag_dy)
	);

	rdj_div #(.DW(64)) u_div_dz (
		.clk(clk), .en(en), .rem0({32'd0, rho_m[63:32]}), .low({rho_m[31:0], 16'd0}),
		.dvsr(fr_m.r2), .mag(mag_dz)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0].neg_rx <= !fr_m.ny;
			side_s[0].neg_ry <= fr_m.nx;
			side_s[0].neg_dx <= fr_m.nx == fr_m.nz;
			side_s[0].neg_dy <= fr_m.ny == fr_m.nz;
			side_s[0].axis <= fr_m.axis;
			for (int i = 1; i < DL; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s[DL-1].axis) begin
				jac_q.dra_dx <= '0;
				jac_q.dra_dy <= '0;
				jac_q.ddecl_dx <= '0;
				jac_q.ddecl_dy <= '0;
				jac_q.ddecl_dz <= '0;
				jac_q.on_axis <= 1'b1;
			end else begin
				jac_q.dra_dx <= pack48(mag_rx, side_s[DL-1].neg_rx);
				jac_q.dra_dy <= pack48(mag_ry, side_s[DL-1].neg_ry);
				jac_q.ddecl_dx <= pack48(mag_dx, side_s[DL-1].neg_dx);
				jac_q.ddecl_dy <= pack48(mag_dy, side_s[DL-1].neg_dy);
				jac_q.ddecl_dz <= pack48(mag_dz, 1'b0);
				jac_q.on_axis <= 1'b0;
			end
		end
	end

	assign jac_valid = jac_valid_q;
	assign jac = jac_q;

	assign derivs_zero = (jac.dra_dx == 48'sd0) && (jac.dra_dy == 48'sd0) &&
		(jac.ddecl_dx == 48'sd0) && (jac.ddecl_dy == 48'sd0) && (jac.ddecl_dz == 48'sd0);

	`RDJ_ASSERT_NOW(a_axis_zero, jac_valid && jac.on_axis, derivs_zero)
	`RDJ_ASSERT_NOW(a_dz_nonneg, jac_valid, !jac.ddecl_dz[47])
	`RDJ_ASSERT_NEXT(a_accept_fills, pos_valid && pos_ready, vld_s[0])
	`RDJ_ASSERT_NEXT(a_stall_holds, !en, vld_s[LAT-1:1] == $past(vld_s[LAT-1:1]))

endmodule

// ===== rtl/rdj_front.sv =====
// Front end: magnitudes, products and sums of squares (three stages).
// Depends on rdj_pkg.
module rdj_front (
	input logic clk,
	input logic ld,
	input logic en,
	input rdj_pkg::pos_t pos,
	output rdj_pkg::front_t fr
);

	typedef struct packed {
		logic [31:0] mx;
		logic [31:0] my;
		logic [31:0] mz;
		logic nx;
		logic ny;
		logic nz;
	} mag_t;

	typedef struct packed {
		logic [31:0] mx;
		logic [31:0] my;
		logic [63:0] xx;
		logic [63:0] yy;
		logic [63:0] zz;
		logic [63:0] mxz;
		logic [63:0] myz;
		logic nx;
		logic ny;
		logic nz;
	} prod_t;

	mag_t mag_s1;
	prod_t prod_s2;
	rdj_pkg::front_t fr_s3;

	always_ff @(posedge clk) begin
		if (ld) begin
			mag_s1.nx <= pos.pos_x[31];
			mag_s1.ny <= pos.pos_y[31];
			mag_s1.nz <= pos.pos_z[31];
			mag_s1.mx <= pos.pos_x[31] ? (~pos.pos_x + 32'd1) : pos.pos_x;
			mag_s1.my <= pos.pos_y[31] ? (~pos.pos_y + 32'd1) : pos.pos_y;
			mag_s1.mz <= pos.pos_z[31] ? (~pos.pos_z + 32'd1) : pos.pos_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2.mx <= mag_s1.mx;
			prod_s2.my <= mag_s1.my;
			prod_s2.xx <= 64'(mag_s1.mx) * 64'(mag_s1.mx);
			prod_s2.yy <= 64'(mag_s1.my) * 64'(mag_s1.my);
			prod_s2.zz <= 64'(mag_s1.mz) * 64'(mag_s1.mz);
			prod_s2.mxz <= 64'(mag_s1.mx) * 64'(mag_s1.mz);
			prod_s2.myz <= 64'(mag_s1.my) * 64'(mag_s1.mz);
			prod_s2.nx <= mag_s1.nx;
			prod_s2.ny <= mag_s1.ny;
			prod_s2.nz <= mag_s1.nz;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s3.mx <= prod_s2.mx;
			fr_s3.my <= prod_s2.my;
			fr_s3.mxz <= prod_s2.mxz;
			fr_s3.myz <= prod_s2.myz;
			fr_s3.s <= prod_s2.xx + prod_s2.yy;
			fr_s3.r2 <= prod_s2.xx + prod_s2.yy + prod_s2.zz;
			fr_s3.nx <= prod_s2.nx;
			fr_s3.ny <= prod_s2.ny;
			fr_s3.nz <= prod_s2.nz;
			fr_s3.axis <= (prod_s2.mx == 32'd0) && (prod_s2.my == 32'd0);
		end
	end

	assign fr = fr_s3;

endmodule

// ===== rtl/rdj_sqrt.sv =====
// Digit-by-digit square root of s * 2^64, one root bit per stage.
// Depends on rdj_pkg.
module rdj_sqrt (
	input logic clk,
	input logic en,
	input rdj_pkg::front_t fr_in,
	output rdj_pkg::front_t fr_out,
	output logic [63:0] rho
);

	localparam int unsigned NS = rdj_pkg::SQ_STEPS;

	logic [65:0] rem_s [NS];
	logic [63:0] root_s [NS];
	rdj_pkg::front_t fr_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_step
		logic [65:0] prev_rem;
		logic [63:0] prev_root;
		rdj_pkg::front_t prev_fr;
		logic [1:0] pair;
		logic [67:0] rx;
		logic [67:0] trial;
		logic ge;

		if (k == 0) begin : g_first
			assign prev_rem = '0;
			assign prev_root = '0;
			assign prev_fr = fr_in;
		end else begin : g_next
			assign prev_rem = rem_s[k-1];
			assign prev_root = root_s[k-1];
			assign prev_fr = fr_s[k-1];
		end

		if (k < NS / 2) begin : g_hi
			assign pair = prev_fr.s[63 - 2 * k -: 2];
		end else begin : g_lo
			assign pair = 2'b00;
		end

		assign rx = {prev_rem, pair};
		assign trial = {2'b00, prev_root, 2'b01};
		assign ge = rx >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? 66'(rx - trial) : rx[65:0];
				root_s[k] <= {prev_root[62:0], ge};
				fr_s[k] <= prev_fr;
			end
		end
	end

	assign fr_out = fr_s[NS-1];
	assign rho = root_s[NS-1];

endmodule

// ===== rtl/rdj_dmul.sv =====
// Divisor product r2 * rho in 32x32 partial products over three stages.
// Depends on rdj_pkg.
module rdj_dmul (
	input logic clk,
	input logic en,
	input rdj_pkg::front_t fr_in,
	input logic [63:0] rho_in,
	output rdj_pkg::front_t fr_out,
	output logic [63:0] rho_out,
	output logic [127:0] dvsr
);

	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [63:0] ll_s2, hh_s2;
	logic [64:0] mid_s2;
	logic [127:0] dvsr_s3;
	rdj_pkg::front_t fr_s1, fr_s2, fr_s3;
	logic [63:0] rho_s1, rho_s2, rho_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= 64'(fr_in.r2[31:0]) * 64'(rho_in[31:0]);
			lh_s1 <= 64'(fr_in.r2[31:0]) * 64'(rho_in[63:32]);
			hl_s1 <= 64'(fr_in.r2[63:32]) * 64'(rho_in[31:0]);
			hh_s1 <= 64'(fr_in.r2[63:32]) * 64'(rho_in[63:32]);
			fr_s1 <= fr_in;
			rho_s1 <= rho_in;
			ll_s2 <= ll_s1;
			hh_s2 <= hh_s1;
			mid_s2 <= 65'(lh_s1) + 65'(hl_s1);
			fr_s2 <= fr_s1;
			rho_s2 <= rho_s1;
			dvsr_s3 <= {hh_s2, ll_s2} + {31'd0, mid_s2, 32'd0};
			fr_s3 <= fr_s2;
			rho_s3 <= rho_s2;
		end
	end

	assign fr_out = fr_s3;
	assign rho_out = rho_s3;
	assign dvsr = dvsr_s3;

endmodule

// ===== rtl/rdj_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with rounding.
// Depends on rdj_pkg.
module rdj_div #(
	parameter int unsigned DW = 64
) (
	input logic clk,
	input logic en,
	input logic [DW-1:0] rem0,
	input logic [rdj_pkg::QUO_BITS-1:0] low,
	input logic [DW-1:0] dvsr,
	output logic [rdj_pkg::QUO_BITS:0] mag
);

	localparam int unsigned QB = rdj_pkg::QUO_BITS;

	logic [DW-1:0] rem_s [QB+1];
	logic [DW-1:0] dvsr_s [QB+1];
	logic [QB-1:0] low_s [QB];
	logic [QB-1:0] quo_s [QB+1];
	logic ovf_s [QB+1];
	logic [QB:0] mag_q;
	logic rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rem0;
			dvsr_s[0] <= dvsr;
			low_s[0] <= low;
			quo_s[0] <= '0;
			ovf_s[0] <= rem0 >= dvsr;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [DW:0] rx;
		logic [DW:0] dx;
		logic ge;

		assign rx = {rem_s[k-1], low_s[k-1][QB-1]};
		assign dx = {1'b0, dvsr_s[k-1]};
		assign ge = rx >= dx;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(rx - dx) : rx[DW-1:0];
				quo_s[k] <= {quo_s[k-1][QB-2:0], ge};
				dvsr_s[k] <= dvsr_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end

		if (k < QB) begin : g_low
			always_ff @(posedge clk) begin
				if (en) begin
					low_s[k] <= {low_s[k-1][QB-2:0], 1'b0};
				end
			end
		end
	end

	assign rnd = {rem_s[QB], 1'b0} >= {1'b0, dvsr_s[QB]};

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= ovf_s[QB] ? {1'b1, {QB{1'b0}}} : ({1'b0, quo_s[QB]} + (QB+1)'(rnd));
		end
	end

	assign mag = mag_q;

endmodule

// ===== dv/tb_ra_decl_position_jacobian_top.sv =====
// Testbench for ra_decl_position_jacobian_top: directed positions, then random ones,
// with every result checked against a fixed expected value or a wide-integer Jacobian predictor.
// Depends on rdj_pkg and the RTL of the block.
module tb_ra_decl_position_jacobian_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [47:0] JAC_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] JAC_MIN = 48'h8000_0000_0000;
	localparam int RANDOM_ITEMS = 1730;

	typedef struct {
		rdj_pkg::pos_t p;
		bit known;
		rdj_pkg::jac_t e;
	} row_t;

	logic clk;
	logic arst_n;
	logic pos_valid;
	logic pos_ready;
	rdj_pkg::pos_t pos;
	logic jac_valid;
	logic jac_ready;
	rdj_pkg::jac_t jac;

	rdj_pkg::jac_t jac_expected[$];
	int mismatches = 0;
	int cyc = 0;
	bit stim_done = 0;

	ra_decl_position_jacobian_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pos_valid(pos_valid),
		.pos_ready(pos_ready),
		.pos(pos),
		.jac_valid(jac_valid),
		.jac_ready(jac_ready),
		.jac(jac)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [255:0] round_quotient(logic [255:0] num, logic [255:0] den);
		logic [255:0] q;
		logic [255:0] r;
		q = num / den;
		r = num % den;
		if ((r << 1) >= den)
			q = q + 1;
		return q;
	endfunction

	function automatic logic [47:0] sign_saturate(logic [255:0] mag, bit neg);
		if (mag == 0)
			return 48'd0;
		if (neg) begin
			if (mag >= 256'h8000_0000_0000)
				return JAC_MIN;
			return -mag[47:0];
		end
		if (mag > 256'h7FFF_FFFF_FFFF)
			return JAC_MAX;
		return mag[47:0];
	endfunction

	function automatic rdj_pkg::jac_t predict_jacobian(rdj_pkg::pos_t p);
		rdj_pkg::jac_t j;
		bit nx, ny, nz;
		logic [255:0] mx, my, mz, s, r2, rho, cand, den;
		nx = p.pos_x[31];
		ny = p.pos_y[31];
		nz = p.pos_z[31];
		mx = nx ? 256'(-33'(signed'(p.pos_x))) : 256'(p.pos_x);
		my = ny ? 256'(-33'(signed'(p.pos_y))) : 256'(p.pos_y);
		mz = nz ? 256'(-33'(signed'(p.pos_z))) : 256'(p.pos_z);
		j = '0;
		if (mx == 0 && my == 0) begin
			j.on_axis = 1'b1;
			return j;
		end
		s = mx * mx + my * my;
		r2 = s + mz * mz;
		rho = 0;
		for (int b = 63; b >= 0; b--) begin
			cand = rho | (256'd1 << b);
			if (cand * cand <= (s << 64))
				rho = cand;
		end
		den = r2 * rho;
		j.dra_dx = sign_saturate(round_quotient(my << 48, s), !ny);
		j.dra_dy = sign_saturate(round_quotient(mx << 48, s), nx);
		j.ddecl_dx = sign_saturate(round_quotient((mx * mz) << 80, den), nx == nz);
		j.ddecl_dy = sign_saturate(round_quotient((my * mz) << 80, den), ny == nz);
		j.ddecl_dz = sign_saturate(round_quotient(rho << 16, r2), 1'b0);
		return j;
	endfunction

	function automatic logic [31:0] random_coord();
		unique case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			2: return $urandom >>> $urandom_range(8, 31);
			3: return -($urandom >> $urandom_range(8, 31));
			4: return $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_position(rdj_pkg::pos_t p, bit known, rdj_pkg::jac_t e, bit calm);
		if (!calm)
			while ($urandom_range(0, 99) < 6) begin
				pos_valid <= 1'b0;
				@(negedge clk);
			end
		pos_valid <= 1'b1;
		pos <= p;
		do
			@(posedge clk);
		while (!(pos_valid && pos_ready));
		jac_expected.push_back(known ? e : predict_jacobian(p));
		@(negedge clk);
	endtask

	initial begin
		row_t rows[$];
		row_t r;
		rdj_pkg::pos_t p;
		arst_n = 0;
		pos_valid = 0;
		pos = '0;
		jac_ready = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		r.known = 1;
		r.p = '{32'sd0, 32'sd0, 32'sd0};
		r.e = '{48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 1'b1};
		rows.push_back(r);
		r.p = '{32'sd0, 32'sd0, 32'sh8000_0000};
		rows.push_back(r);
		r.p = '{32'sd0, 32'sd0, 32'sh7FFF_FFFF};
		rows.push_back(r);
		r.p = '{32'sh0001_0000, 32'sd0, 32'sd0};
		r.e = '{48'd0, 48'h1_0000_0000, 48'd0, 48'd0, 48'h1_0000_0000, 1'b0};
		rows.push_back(r);
		r.p = '{32'sd1, 32'sd0, 32'sd0};
		r.e = '{48'd0, JAC_MAX, 48'd0, 48'd0, JAC_MAX, 1'b0};
		rows.push_back(r);
		r.p = '{-32'sd1, 32'sd0, 32'sd0};
		r.e = '{48'd0, JAC_MIN, 48'd0, 48'd0, JAC_MAX, 1'b0};
		rows.push_back(r);
		r.known = 0;
		r.e = '0;
		r.p = '{32'sd0, 32'sd1, 32'sd0};
		rows.push_back(r);
		r.p = '{32'sd0, -32'sd1, 32'sd1};
		rows.push_back(r);
		r.p = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		rows.push_back(r);
		r.p = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		rows.push_back(r);
		r.p = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0};
		rows.push_back(r);
		r.p = '{32'sd1, 32'sd1, 32'sh8000_0000};
		rows.push_back(r);
		r.p = '{-32'sd1, 32'sd1, 32'sh7FFF_FFFF};
		rows.push_back(r);
		r.p = '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000};
		rows.push_back(r);
		r.p = '{-32'sh0003_0000, 32'sh0004_0000, -32'sh0005_0000};
		rows.push_back(r);
		r.p = '{32'sh7FFF_FFFF, 32'sd1, -32'sd1};
		rows.push_back(r);
		r.p = '{32'sd3, -32'sh8000_0000, 32'sh1234_5678};
		rows.push_back(r);
		r.p = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F};
		rows.push_back(r);

		foreach (rows[i])
			send_position(rows[i].p, rows[i].known, rows[i].e, 0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			p.pos_x = random_coord();
			p.pos_y = random_coord();
			p.pos_z = random_coord();
			send_position(p, 0, '0, n >= 1200 && n < 1500);
		end
		pos_valid <= 1'b0;
		stim_done = 1;
	end

	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc >= 1000 && cyc < 1400)
				jac_ready <= 1'b0;
			else if (cyc >= 1600 && cyc < 1900)
				jac_ready <= 1'b1;
			else
				jac_ready <= $urandom_range(0, 99) >= 6;
		end
	end

	always @(posedge clk) begin
		rdj_pkg::jac_t want;
		if (arst_n && jac_valid && jac_ready) begin
			if (jac_expected.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, jac);
				mismatches++;
			end else begin
				want = jac_expected.pop_front();
				if (jac.dra_dx !== want.dra_dx) begin
					$display("%0t: dra_dx exp %h got %h", $realtime, want.dra_dx, jac.dra_dx);
					mismatches++;
				end
				if (jac.dra_dy !== want.dra_dy) begin
					$display("%0t: dra_dy exp %h got %h", $realtime, want.dra_dy, jac.dra_dy);
					mismatches++;
				end
				if (jac.ddecl_dx !== want.ddecl_dx) begin
					$display("%0t: ddecl_dx exp %h got %h", $realtime, want.ddecl_dx,
						jac.ddecl_dx);
					mismatches++;
				end
				if (jac.ddecl_dy !== want.ddecl_dy) begin
					$display("%0t: ddecl_dy exp %h got %h", $realtime, want.ddecl_dy,
						jac.ddecl_dy);
					mismatches++;
				end
				if (jac.ddecl_dz !== want.ddecl_dz) begin
					$display("%0t: ddecl_dz exp %h got %h", $realtime, want.ddecl_dz,
						jac.ddecl_dz);
					mismatches++;
				end
				if (jac.on_axis !== want.on_axis) begin
					$display("%0t: on_axis exp %b got %b", $realtime, want.on_axis,
						jac.on_axis);
					mismatches++;
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		while (jac_expected.size() != 0)
			@(posedge clk);
		repeat (rdj_pkg::PIPE_LAT + 40) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/rdj_pkg.sv
rtl/rdj_front.sv
rtl/rdj_sqrt.sv
rtl/rdj_dmul.sv
rtl/rdj_div.sv
rtl/ra_decl_position_jacobian_top.sv
dv/tb_ra_decl_position_jacobian_top.sv
